[sv/spsc_pkg.sv]
// Package with the shared constants and types of the stack pop-sequence checker.
package spsc_pkg;

    localparam int MAX_VALUE = 1024;
    localparam int RUN_DEPTH = 1024;

    // Widths of the item fields and of the configuration registers.
    localparam int VAL_W = 11;
    localparam int CFG_W = 11;
    localparam int CFG_IDX_W = 1;

    // Run memory geometry: an entry holds the lowest and highest value left in a run.
    localparam int RUN_AW = $clog2(RUN_DEPTH);
    localparam int RUN_CW = $clog2(RUN_DEPTH + 1);
    localparam int RUN_VW = $clog2(MAX_VALUE);

    // Occupancy never exceeds the largest value, one bit more covers the capacity check.
    localparam int OCC_W = VAL_W;

    localparam logic [CFG_IDX_W-1:0] REG_STACK_CAPACITY = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SEQUENCE_LENGTH = CFG_IDX_W'(1);

    typedef struct packed {
        logic [RUN_VW-1:0] lo;
        logic [RUN_VW-1:0] hi;
    } run_entry_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

endpackage

[sv/stack_pop_sequence_checker.sv]
// Top level of the stack pop-sequence checker: item buffer, run memory and verdict logic.
//
//  Channel  | Direction | Content
//  ---------+-----------+-------------------------------------------------------------
//  s_axis   | in        | tdata[10:0] pop_value, tuser first_item, tlast last_item
//  m_axis   | out       | tdata[0] still_possible, tlast sequence_end
//  cfg      | in        | cfg_we, cfg_index (0 capacity, 1 length), cfg_data[10:0]
//
// Each item is handled in the idle state, which reads the top run from the run memory,
// and then in the exec state, which checks the value, updates the state and writes the run
// back. A one-item input buffer takes the next item during the check, and an output
// register holds the verdict until it is taken; a stalled output holds the check.
// Reset clears the control state at once; the run memory needs no clearing pass because
// only entries below the run count are ever used.
module stack_pop_sequence_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [15:0]                     s_axis_tdata,   // [10:0] pop_value, rest zero
    input  logic                            s_axis_tuser,   // [0] first_item
    input  logic                            s_axis_tlast,   // last_item
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [7:0]                      m_axis_tdata,   // [0] still_possible, rest zero
    output logic                            m_axis_tlast,   // sequence_end
    input  logic                            cfg_we,
    input  logic [spsc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [spsc_pkg::CFG_W-1:0]      cfg_data
);

    // Configuration registers.
    logic [spsc_pkg::CFG_W-1:0] capacity_reg;
    logic [spsc_pkg::CFG_W-1:0] length_reg;

    // Input buffer.
    logic                       buf_valid_reg;
    logic [spsc_pkg::VAL_W-1:0] buf_value_reg;
    logic                       buf_first_reg;
    logic                       buf_last_reg;

    // Item under check.
    logic [spsc_pkg::VAL_W-1:0] work_value_reg;
    logic                       work_first_reg;
    logic                       work_last_reg;

    // Sequence state.
    logic [spsc_pkg::VAL_W-1:0]  npv_reg, npv_next;
    logic [spsc_pkg::RUN_CW-1:0] rc_reg, rc_next;
    logic [spsc_pkg::OCC_W-1:0]  occ_reg, occ_next;
    logic                        fail_reg, fail_next;

    // Output register.
    logic out_valid_reg, out_valid_next;
    logic out_still_reg;
    logic out_end_reg;

    // Control.
    spsc_pkg::state_t state_reg, state_next;
    logic mem_re;
    logic exec_done;

    // Run memory.
    spsc_pkg::run_entry_t run_mem [spsc_pkg::RUN_DEPTH];
    spsc_pkg::run_entry_t rdata_reg;
    logic                        mem_we;
    logic [spsc_pkg::RUN_AW-1:0] mem_waddr;
    spsc_pkg::run_entry_t        mem_wdata;
    logic [spsc_pkg::RUN_AW-1:0] mem_raddr;
    logic [spsc_pkg::RUN_CW-1:0] rc_minus1;

    logic in_accept;
    logic out_free;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !buf_valid_reg;
    assign out_free = !out_valid_reg || m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'b0, out_still_reg};
    assign m_axis_tlast  = out_end_reg;

    // The top run sits at run_count - 1; the value is unused when the stack is empty.
    assign rc_minus1 = rc_reg - spsc_pkg::RUN_CW'(1);
    assign mem_raddr = rc_minus1[spsc_pkg::RUN_AW-1:0];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            spsc_pkg::ST_IDLE:
            begin
                if (buf_valid_reg)
                    state_next = spsc_pkg::ST_EXEC;
            end
            spsc_pkg::ST_EXEC:
            begin
                if (out_free)
                    state_next = spsc_pkg::ST_IDLE;
            end
            default:
                state_next = spsc_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        mem_re = 1'b0;
        exec_done = 1'b0;
        case (state_reg)
            spsc_pkg::ST_IDLE:
                mem_re = buf_valid_reg;
            spsc_pkg::ST_EXEC:
                exec_done = out_free;
            default:
            begin
                mem_re = 1'b0;
                exec_done = 1'b0;
            end
        endcase
    end

    // Check of one value against the top run, with the pop from it or the push of a new run where needed.
    always_comb
    begin
        logic [spsc_pkg::VAL_W-1:0]  len_eff;
        logic [spsc_pkg::VAL_W-1:0]  npv_c;
        logic [spsc_pkg::RUN_CW-1:0] rc_c;
        logic [spsc_pkg::OCC_W-1:0]  occ_c;
        logic                        fail_c;
        logic [spsc_pkg::VAL_W-1:0]  cnt;
        logic [spsc_pkg::OCC_W:0]    occ_sum;
        logic [spsc_pkg::VAL_W-1:0]  v;
        logic [spsc_pkg::VAL_W-1:0]  v_minus1;
        logic [spsc_pkg::RUN_CW-1:0] rc_top;

        len_eff = (length_reg > spsc_pkg::CFG_W'(spsc_pkg::MAX_VALUE)) ?
                  spsc_pkg::VAL_W'(spsc_pkg::MAX_VALUE) : spsc_pkg::VAL_W'(length_reg);
        v = work_value_reg;
        v_minus1 = v - spsc_pkg::VAL_W'(1);

        if (work_first_reg)
        begin
            npv_c = spsc_pkg::VAL_W'(1);
            rc_c = '0;
            occ_c = '0;
            fail_c = 1'b0;
        end
        else
        begin
            npv_c = npv_reg;
            rc_c = rc_reg;
            occ_c = occ_reg;
            fail_c = fail_reg;
        end

        rc_top = rc_c - spsc_pkg::RUN_CW'(1);
        cnt = v - npv_c + spsc_pkg::VAL_W'(1);
        occ_sum = {1'b0, occ_c} + {{(spsc_pkg::OCC_W + 1 - spsc_pkg::VAL_W){1'b0}}, cnt};

        mem_we = 1'b0;
        mem_waddr = rc_top[spsc_pkg::RUN_AW-1:0];
        mem_wdata = rdata_reg;

        npv_next = npv_c;
        rc_next = rc_c;
        occ_next = occ_c;
        fail_next = fail_c;

        if (!fail_c)
        begin
            if (v == '0 || v > len_eff)
                fail_next = 1'b1;
            else if (rc_c != '0 &&
                     v == {{(spsc_pkg::VAL_W - spsc_pkg::RUN_VW){1'b0}}, rdata_reg.hi})
            begin
                // Pop the top value; an emptied run leaves the stack.
                if (rdata_reg.hi <= rdata_reg.lo)
                    rc_next = rc_top;
                else
                begin
                    mem_we = 1'b1;
                    mem_wdata.lo = rdata_reg.lo;
                    mem_wdata.hi = rdata_reg.hi - spsc_pkg::RUN_VW'(1);
                end
                occ_next = occ_c - spsc_pkg::OCC_W'(1);
            end
            else if (v >= npv_c)
            begin
                if (occ_sum > {{(spsc_pkg::OCC_W + 1 - spsc_pkg::CFG_W){1'b0}}, capacity_reg})
                    fail_next = 1'b1;
                else if (v > npv_c && rc_c >= spsc_pkg::RUN_CW'(spsc_pkg::RUN_DEPTH))
                    fail_next = 1'b1;
                else
                begin
                    if (v > npv_c)
                    begin
                        mem_we = 1'b1;
                        mem_waddr = rc_c[spsc_pkg::RUN_AW-1:0];
                        mem_wdata.lo = npv_c[spsc_pkg::RUN_VW-1:0];
                        mem_wdata.hi = v_minus1[spsc_pkg::RUN_VW-1:0];
                        rc_next = rc_c + spsc_pkg::RUN_CW'(1);
                    end
                    occ_next = occ_sum[spsc_pkg::OCC_W-1:0] - spsc_pkg::OCC_W'(1);
                    npv_next = v + spsc_pkg::VAL_W'(1);
                end
            end
            else
                fail_next = 1'b1;
        end

        // A last item succeeds only when every value has been pushed and popped.
        if (work_last_reg && !fail_next && (occ_next != '0 || npv_next <= len_eff))
            fail_next = 1'b1;

        if (!exec_done)
            mem_we = 1'b0;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (exec_done)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            run_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rdata_reg <= run_mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= spsc_pkg::CFG_W'(5);
            length_reg <= spsc_pkg::CFG_W'(7);
            buf_valid_reg <= 1'b0;
            state_reg <= spsc_pkg::ST_IDLE;
            npv_reg <= spsc_pkg::VAL_W'(1);
            rc_reg <= '0;
            occ_reg <= '0;
            fail_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    spsc_pkg::REG_STACK_CAPACITY:  capacity_reg <= cfg_data;
                    spsc_pkg::REG_SEQUENCE_LENGTH: length_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (in_accept)
                buf_valid_reg <= 1'b1;
            else if (mem_re)
                buf_valid_reg <= 1'b0;
            state_reg <= state_next;
            if (exec_done)
            begin
                npv_reg <= npv_next;
                rc_reg <= rc_next;
                occ_reg <= occ_next;
                fail_reg <= fail_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            buf_value_reg <= s_axis_tdata[spsc_pkg::VAL_W-1:0];
            buf_first_reg <= s_axis_tuser;
            buf_last_reg <= s_axis_tlast;
        end
        if (mem_re)
        begin
            work_value_reg <= buf_value_reg;
            work_first_reg <= buf_first_reg;
            work_last_reg <= buf_last_reg;
        end
        if (exec_done)
        begin
            out_still_reg <= !fail_next;
            out_end_reg <= work_last_reg;
        end
    end

endmodule
